### sv/cron_schedule_field_parser_macros.svh
// ----------------------------------------------------------------------------
// Cron schedule field parser assertion macros
// Shorthand for the clocked assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CRON_SCHEDULE_FIELD_PARSER_MACROS_SVH
`define CRON_SCHEDULE_FIELD_PARSER_MACROS_SVH

// Checked only while the block is out of reset.
`define CSFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CSFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/csfp_pkg.sv
// ----------------------------------------------------------------------------
// csfp_pkg
// Shared types, constants and field tables of the cron schedule field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package csfp_pkg;

  localparam int OUT_DATA_W = 136;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] ANY_VALUE = 8'hff;
  localparam logic [7:0] SAT_MAX   = 8'hff;

  localparam logic [2:0] FLD_MINUTE  = 3'd0;
  localparam logic [2:0] FLD_HOUR    = 3'd1;
  localparam logic [2:0] FLD_DAY     = 3'd2;
  localparam logic [2:0] FLD_MONTH   = 3'd3;
  localparam logic [2:0] FLD_WEEKDAY = 3'd4;

  localparam logic [1:0] PART_START      = 2'd0;
  localparam logic [1:0] PART_END        = 2'd1;
  localparam logic [1:0] PART_STEP_ONE   = 2'd2;
  localparam logic [1:0] PART_STEP_RANGE = 2'd3;

  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_SPACE = 2'd1;
  localparam logic [1:0] SEP_COMMA = 2'd2;

  typedef struct packed {
    logic       load;
    logic       apply_char;
    logic       setup;
    logic       walk;
    logic       end_item;
    logic [1:0] sep;
    logic       emit;
  } csfp_cmd_t;

  typedef struct packed {
    logic sep_finish;
    logic sep_space;
    logic is_eol;
    logic comment;
    logic item_live;
    logic walk_done;
    logic out_busy;
  } csfp_sts_t;

  function automatic logic field_low_one(input logic [2:0] f);
    return (f == FLD_DAY) || (f == FLD_MONTH);
  endfunction

  function automatic logic [7:0] field_high(input logic [2:0] f);
    logic [7:0] h;
    case (f)
      FLD_MINUTE:  h = 8'd59;
      FLD_HOUR:    h = 8'd23;
      FLD_DAY:     h = 8'd31;
      FLD_MONTH:   h = 8'd12;
      default:     h = 8'd6;
    endcase
    return h;
  endfunction

  function automatic logic [5:0] field_width(input logic [2:0] f);
    logic [5:0] w;
    case (f)
      FLD_MINUTE:  w = 6'd60;
      FLD_HOUR:    w = 6'd24;
      FLD_DAY:     w = 6'd31;
      FLD_MONTH:   w = 6'd12;
      default:     w = 6'd7;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [3:0] d);
    logic [11:0] n;
    n = {4'd0, v} * 12'd10 + {8'd0, d};
    return (n > {4'd0, SAT_MAX}) ? SAT_MAX : n[7:0];
  endfunction

endpackage

`default_nettype wire

### sv/cron_schedule_field_parser.sv
// ----------------------------------------------------------------------------
// cron_schedule_field_parser: crontab time fields to five match masks
// A plain character is loaded and then decoded; a closing space or comma is then set up,
// runs a mask walk of one position per cycle with an extra step for a range wrap, and ends the item.
// The line end loads the result; sync reset clears control, mask and item state.
// ----------------------------------------------------------------------------
`default_nettype none

module cron_schedule_field_parser (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // [7:0] ch
  input  wire  [7:0]                        in_tdata,
  input  wire                               in_tlast,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [59:0] minute_mask, [83:60] hour_mask, [114:84] day_mask,
  // [126:115] month_mask, [133:127] weekday_mask, [135:134] zero
  output logic [csfp_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [0] is_comment
  output logic                              out_tuser
);
  import csfp_pkg::*;

  csfp_cmd_t cmd;
  csfp_sts_t sts;

  csfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csfp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_tdata),
    .in_eol      (in_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_comment (out_tuser)
  );

endmodule

`default_nettype wire

### sv/csfp_ctrl.sv
// ----------------------------------------------------------------------------
// csfp_ctrl
// Sequencer: takes a character, lets the datapath decode it, runs the mask
// walk for a finished item and hands the line result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csfp_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  csfp_pkg::csfp_sts_t  sts,
  output csfp_pkg::csfp_cmd_t  cmd
);
  import csfp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_END    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] sep_r, sep_nxt;

  always_comb begin
    state_nxt = state_r;
    sep_nxt   = sep_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sep   = sep_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.apply_char = 1'b1;
        if (sts.sep_finish) begin
          sep_nxt   = sts.sep_space ? SEP_SPACE : SEP_COMMA;
          state_nxt = S_SETUP;
        end else if (sts.is_eol && !sts.comment) begin
          sep_nxt   = SEP_NONE;
          state_nxt = S_SETUP;
        end else if (sts.is_eol) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SETUP: begin
        if (sts.item_live) begin
          cmd.setup = 1'b1;
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_END;
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_nxt = S_END;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_END: begin
        cmd.end_item = 1'b1;
        state_nxt    = sts.is_eol ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sep_r   <= SEP_NONE;
    end else begin
      state_r <= state_nxt;
      sep_r   <= sep_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/csfp_dp.sv
// ----------------------------------------------------------------------------
// csfp_dp
// Datapath: item fields, the five field masks, the one-position-per-cycle
// mask walk and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csfp_dp (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  [7:0]                        in_ch,
  input  wire                               in_eol,
  input  csfp_pkg::csfp_cmd_t               cmd,
  output csfp_pkg::csfp_sts_t               sts,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [csfp_pkg::OUT_DATA_W-1:0]   out_data,
  output logic                              out_comment
);
  import csfp_pkg::*;

  logic [7:0]         ch_r;
  logic               eol_r;
  logic [2:0]         field_r;
  logic [59:0]        minute_r;
  logic [23:0]        hour_r;
  logic [30:0]        day_r;
  logic [11:0]        month_r;
  logic [6:0]         weekday_r;
  logic [7:0]         start_r;
  logic [7:0]         end_r;
  logic [7:0]         step_r;
  logic [1:0]         part_r;
  logic               star_r;
  logic               item_has_r;
  logic               field_started_r;
  logic               comment_r;
  logic               line_start_r;
  logic signed [9:0]  pos_r;
  logic signed [9:0]  to_rel_r;
  logic [7:0]         wstep_r;
  logic               phase_a_r;
  logic [5:0]         width_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic               out_comment_r;

  logic               comment_eff;
  logic               active;
  logic               is_digit;
  logic [3:0]         digit;
  logic               low_one;
  logic [7:0]         high_val;
  logic               use_range;
  logic [7:0]         from_raw;
  logic [7:0]         to_raw;
  logic [7:0]         from_val;
  logic [7:0]         to_val;
  logic signed [9:0]  from_rel;
  logic signed [9:0]  to_rel;
  logic [7:0]         step_eff;
  logic signed [9:0]  width_s;
  logic signed [9:0]  step_s;
  logic               in_field;
  logic               b_go;
  logic               set_en;
  logic [63:0]        onehot;

  assign comment_eff = comment_r | (line_start_r && (ch_r == CH_HASH));
  assign active      = !comment_eff && (field_r <= FLD_WEEKDAY);
  assign is_digit    = (ch_r >= CH_ZERO) && (ch_r <= CH_NINE);
  assign digit       = ch_r[3:0];

  assign low_one   = field_low_one(field_r);
  assign high_val  = field_high(field_r);
  assign use_range = (part_r == PART_END) || (part_r == PART_STEP_RANGE);

  always_comb begin
    from_raw = start_r;
    to_raw   = start_r;
    if (use_range) begin
      from_raw = start_r;
      to_raw   = end_r;
    end else if (star_r) begin
      from_raw = ANY_VALUE;
      to_raw   = ANY_VALUE;
    end
    from_val = from_raw;
    to_val   = to_raw;
    if ((from_raw == ANY_VALUE) && (to_raw == ANY_VALUE)) begin
      from_val = {7'd0, low_one};
      to_val   = high_val;
    end
    step_eff = (part_r >= PART_STEP_ONE) ? step_r : 8'd1;
    if (step_eff == 8'd0) begin
      step_eff = 8'd1;
    end
  end

  assign from_rel = signed'({2'b00, from_val}) - signed'({9'd0, low_one});
  assign to_rel   = signed'({2'b00, to_val}) - signed'({9'd0, low_one});

  assign width_s  = signed'({4'd0, width_r});
  assign step_s   = signed'({2'b00, wstep_r});
  assign in_field = (pos_r >= 10'sd0) && (pos_r < width_s);
  assign b_go     = (pos_r <= to_rel_r) && (pos_r < width_s);
  assign set_en   = cmd.walk && in_field && (phase_a_r || b_go);
  assign onehot   = 64'd1 << pos_r[5:0];

  always_comb begin
    sts            = '0;
    sts.sep_finish = active && (((ch_r == CH_SPACE) && field_started_r) ||
                                (ch_r == CH_COMMA));
    sts.sep_space  = (ch_r == CH_SPACE);
    sts.is_eol     = eol_r;
    sts.comment    = comment_eff;
    sts.item_live  = item_has_r && (field_r <= FLD_WEEKDAY);
    sts.walk_done  = !phase_a_r && !b_go;
    sts.out_busy   = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r  <= in_ch;
      eol_r <= in_eol;
    end
    if (cmd.setup) begin
      pos_r     <= from_rel;
      to_rel_r  <= to_rel;
      wstep_r   <= step_eff;
      phase_a_r <= (from_val > to_val);
      width_r   <= field_width(field_r);
    end else if (cmd.walk) begin
      if (phase_a_r && !in_field) begin
        pos_r     <= pos_r - width_s;
        phase_a_r <= 1'b0;
      end else begin
        pos_r <= pos_r + step_s;
      end
    end
    if (cmd.emit) begin
      out_data_r    <= comment_r ? '0 :
                       {2'b00, weekday_r, month_r, day_r, hour_r, minute_r};
      out_comment_r <= comment_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r         <= FLD_MINUTE;
      minute_r        <= '0;
      hour_r          <= '0;
      day_r           <= '0;
      month_r         <= '0;
      weekday_r       <= '0;
      start_r         <= '0;
      end_r           <= '0;
      step_r          <= '0;
      part_r          <= PART_START;
      star_r          <= 1'b0;
      item_has_r      <= 1'b0;
      field_started_r <= 1'b0;
      comment_r       <= 1'b0;
      line_start_r    <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.apply_char) begin
        comment_r    <= comment_eff;
        line_start_r <= 1'b0;
        if (active) begin
          if (is_digit) begin
            field_started_r <= 1'b1;
            item_has_r      <= 1'b1;
            case (part_r)
              PART_START: start_r <= add_digit(start_r, digit);
              PART_END:   end_r   <= add_digit(end_r, digit);
              default:    step_r  <= add_digit(step_r, digit);
            endcase
          end else if (ch_r == CH_STAR) begin
            field_started_r <= 1'b1;
            item_has_r      <= 1'b1;
            star_r          <= 1'b1;
          end else if (ch_r == CH_DASH) begin
            field_started_r <= 1'b1;
            item_has_r      <= 1'b1;
            if (part_r == PART_START) begin
              part_r <= PART_END;
            end
          end else if (ch_r == CH_SLASH) begin
            field_started_r <= 1'b1;
            item_has_r      <= 1'b1;
            if (part_r == PART_START) begin
              part_r <= PART_STEP_ONE;
            end else if (part_r == PART_END) begin
              part_r <= PART_STEP_RANGE;
            end
          end
        end
      end

      if (set_en) begin
        case (field_r)
          FLD_MINUTE:  minute_r  <= minute_r | onehot[59:0];
          FLD_HOUR:    hour_r    <= hour_r | onehot[23:0];
          FLD_DAY:     day_r     <= day_r | onehot[30:0];
          FLD_MONTH:   month_r   <= month_r | onehot[11:0];
          default:     weekday_r <= weekday_r | onehot[6:0];
        endcase
      end

      if (cmd.end_item) begin
        start_r    <= '0;
        end_r      <= '0;
        step_r     <= '0;
        part_r     <= PART_START;
        star_r     <= 1'b0;
        item_has_r <= 1'b0;
        case (cmd.sep)
          SEP_SPACE: begin
            field_r         <= field_r + 3'd1;
            field_started_r <= 1'b0;
          end
          SEP_COMMA: begin
            field_started_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (cmd.emit) begin
        field_r         <= FLD_MINUTE;
        minute_r        <= '0;
        hour_r          <= '0;
        day_r           <= '0;
        month_r         <= '0;
        weekday_r       <= '0;
        start_r         <= '0;
        end_r           <= '0;
        step_r          <= '0;
        part_r          <= PART_START;
        star_r          <= 1'b0;
        item_has_r      <= 1'b0;
        field_started_r <= 1'b0;
        comment_r       <= 1'b0;
        line_start_r    <= 1'b1;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign out_comment = out_comment_r;

endmodule

`default_nettype wire

### sv/csfp_chk.sv
// ----------------------------------------------------------------------------
// csfp_chk
// Port-level checks of the cron schedule field parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cron_schedule_field_parser_macros.svh"

module csfp_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [csfp_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire                              out_tuser
);
  import csfp_pkg::*;

  logic in_fire;

  assign in_fire = in_tvalid && in_tready;

  // A comment line carries no mask bits and padding is always zero.
  `CSFP_ASSERT(a_comment_masks_zero, out_tvalid && out_tuser |-> out_tdata == '0, "comment result has mask bits")
  `CSFP_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[OUT_DATA_W-1:OUT_DATA_W-2] == 2'b00, "padding bits set")
  // Characters are decoded one at a time.
  `CSFP_ASSERT(a_one_at_a_time, in_fire |=> !in_tready, "second request taken while decoding")
  `CSFP_ASSERT(a_out_holds, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `CSFP_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind cron_schedule_field_parser csfp_chk u_csfp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
